>>> hw/rtl/tga_pkg.sv
package tga_pkg;

    // Parser phase
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_PACKET = 3'd1,
        PH_PIXEL  = 3'd2,
        PH_DONE   = 3'd3,
        PH_ERROR  = 3'd4
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_PIXEL    = 2'd0,
        ST_BAD_TYPE = 2'd1,
        ST_BAD_SIZE = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // Header layout and constants
    localparam logic [4:0] HDR_TYPE_IDX   = 5'd2;
    localparam logic [4:0] HDR_PATTERN_END = 5'd12;
    localparam logic [4:0] HDR_WIDTH_LO   = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI   = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] HDR_DEPTH_IDX  = 5'd16;
    localparam logic [7:0] TYPE_RAW       = 8'd2;
    localparam logic [7:0] TYPE_RLE       = 8'd10;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;
    localparam logic [7:0] RUN_BASE       = 8'd127;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       file_start;
    } in_word_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       has_alpha;
        logic [7:0] repeat_count;
        logic       last_pixel;
        logic [1:0] status;
    } out_word_t;

endpackage

>>> hw/rtl/tga_rle_image_decoder_unit.sv
// Targa stream decoder (uncompressed and run-length coded, 24/32 bpp).
// Byte channel (byte_valid/byte_ready/byte_word): one file byte per word;
// file_start marks header byte 0 of a new file and restarts the parser.
// Pixel channel (pixel_valid/pixel_ready/pixel_word): one word per raw
// pixel or per run, in RGBA order, with repeat_count 1..128 for runs, or an
// error word (status nonzero, other fields zero) after which bytes are
// dropped until the next file_start. Bytes after the final pixel are dropped.
// Timing: one byte per cycle while not stalled. A result appears on the pixel
// channel the cycle after the byte that completes it; the per-byte work is a
// single pass through the parse logic into the output register. The pixel
// count width*height comes from one 16x16 multiply at header byte 17.
// Reset: parser returns to the header phase, output register empties.
// Stall: while a result is held, a new byte is still taken if the held
// result leaves in the same cycle; otherwise byte_ready drops until
// pixel_ready takes the held word.
module tga_rle_image_decoder_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    output logic               byte_ready,
    input  tga_pkg::in_word_t  byte_word,
    output logic               pixel_valid,
    input  logic               pixel_ready,
    output tga_pkg::out_word_t pixel_word
);

    tga_pkg::phase_t    phase_reg, phase_next, phase_cur;
    logic [4:0]         hdr_idx_reg, hdr_idx_next, hdr_idx_cur;
    logic [15:0]        width_reg, width_next, width_cur;
    logic [15:0]        height_reg, height_next, height_cur;
    logic               comp_reg, comp_next, comp_cur;
    logic               four_reg, four_next, four_cur;
    logic [31:0]        pix_left_reg, pix_left_next, pix_left_cur;
    logic [7:0]         pkt_left_reg, pkt_left_next, pkt_left_cur;
    logic               pkt_run_reg, pkt_run_next, pkt_run_cur;
    logic [23:0]        colour_reg, colour_next, colour_cur;
    logic [1:0]         bip_reg, bip_next, bip_cur;
    logic               valid_reg, valid_next;
    tga_pkg::out_word_t word_reg, word_next;

    logic        accept;
    logic        emit;
    logic [7:0]  b;
    logic [7:0]  count;
    logic        count_run;
    logic [1:0]  need;
    logic [7:0]  rep;
    logic [31:0] pix_after;
    logic        hdr_err;
    logic        size_err;
    logic        pkt_err;

    assign accept      = byte_valid && byte_ready;
    assign byte_ready  = !valid_reg || pixel_ready;
    assign pixel_valid = valid_reg;
    assign pixel_word  = word_reg;
    assign b           = byte_word.data_byte;

    // Apply restart before the byte is parsed
    always_comb
    begin
        if (byte_word.file_start)
        begin
            phase_cur    = tga_pkg::PH_HEADER;
            hdr_idx_cur  = '0;
            width_cur    = '0;
            height_cur   = '0;
            comp_cur     = 1'b0;
            four_cur     = 1'b0;
            pix_left_cur = '0;
            pkt_left_cur = '0;
            pkt_run_cur  = 1'b0;
            colour_cur   = '0;
            bip_cur      = '0;
        end
        else
        begin
            phase_cur    = phase_reg;
            hdr_idx_cur  = hdr_idx_reg;
            width_cur    = width_reg;
            height_cur   = height_reg;
            comp_cur     = comp_reg;
            four_cur     = four_reg;
            pix_left_cur = pix_left_reg;
            pkt_left_cur = pkt_left_reg;
            pkt_run_cur  = pkt_run_reg;
            colour_cur   = colour_reg;
            bip_cur      = bip_reg;
        end
    end

    // Decode checks and packet arithmetic
    always_comb
    begin
        hdr_err = 1'b0;
        if (hdr_idx_cur < tga_pkg::HDR_PATTERN_END)
        begin
            if (hdr_idx_cur == tga_pkg::HDR_TYPE_IDX)
                hdr_err = (b != tga_pkg::TYPE_RAW) && (b != tga_pkg::TYPE_RLE);
            else
                hdr_err = (b != 8'd0);
        end
        size_err = (hdr_idx_cur == tga_pkg::HDR_DEPTH_IDX) &&
                   ((width_cur == 16'd0) || (height_cur == 16'd0) ||
                    ((b != tga_pkg::DEPTH_24) && (b != tga_pkg::DEPTH_32)));
        count_run = b[7];
        count     = count_run ? (b - tga_pkg::RUN_BASE) : (b + 8'd1);
        pkt_err   = {24'd0, count} > pix_left_cur;
        need      = four_cur ? 2'd3 : 2'd2;
        rep       = (comp_cur && pkt_run_cur) ? pkt_left_cur : 8'd1;
        pix_after = pix_left_cur - {24'd0, rep};
    end

    // Next phase
    always_comb
    begin
        phase_next = phase_cur;
        unique case (phase_cur) inside
            tga_pkg::PH_HEADER:
            begin
                if (hdr_err || size_err)
                    phase_next = tga_pkg::PH_ERROR;
                else if (hdr_idx_cur > tga_pkg::HDR_DEPTH_IDX)
                    phase_next = comp_cur ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
            end
            tga_pkg::PH_PACKET:
                phase_next = pkt_err ? tga_pkg::PH_ERROR : tga_pkg::PH_PIXEL;
            tga_pkg::PH_PIXEL:
            begin
                if (bip_cur >= need)
                begin
                    if (pix_after == 32'd0)
                        phase_next = tga_pkg::PH_DONE;
                    else if (comp_cur && (pkt_run_cur || pkt_left_cur == 8'd1))
                        phase_next = tga_pkg::PH_PACKET;
                end
            end
            tga_pkg::PH_DONE,
            tga_pkg::PH_ERROR:
                phase_next = phase_cur;
            default:
                phase_next = tga_pkg::PH_ERROR;
        endcase
    end

    // Datapath and result word
    always_comb
    begin
        hdr_idx_next  = hdr_idx_cur;
        width_next    = width_cur;
        height_next   = height_cur;
        comp_next     = comp_cur;
        four_next     = four_cur;
        pix_left_next = pix_left_cur;
        pkt_left_next = pkt_left_cur;
        pkt_run_next  = pkt_run_cur;
        colour_next   = colour_cur;
        bip_next      = bip_cur;
        emit          = 1'b0;
        word_next     = '0;
        unique case (phase_cur) inside
            tga_pkg::PH_HEADER:
            begin
                hdr_idx_next = hdr_idx_cur + 5'd1;
                if (hdr_err)
                begin
                    emit             = 1'b1;
                    word_next.status = tga_pkg::ST_BAD_TYPE;
                end
                else if (size_err)
                begin
                    emit             = 1'b1;
                    word_next.status = tga_pkg::ST_BAD_SIZE;
                end
                else
                begin
                    case (hdr_idx_cur)
                        tga_pkg::HDR_TYPE_IDX:  comp_next = (b == tga_pkg::TYPE_RLE);
                        tga_pkg::HDR_WIDTH_LO:  width_next = {8'd0, b};
                        tga_pkg::HDR_WIDTH_HI:  width_next = {b, width_cur[7:0]};
                        tga_pkg::HDR_HEIGHT_LO: height_next = {8'd0, b};
                        tga_pkg::HDR_HEIGHT_HI: height_next = {b, height_cur[7:0]};
                        tga_pkg::HDR_DEPTH_IDX: four_next = (b == tga_pkg::DEPTH_32);
                        default:
                        begin
                            if (hdr_idx_cur > tga_pkg::HDR_DEPTH_IDX)
                            begin
                                pix_left_next = {16'd0, width_cur} * {16'd0, height_cur};
                                bip_next      = '0;
                                colour_next   = '0;
                                pkt_left_next = '0;
                                pkt_run_next  = 1'b0;
                            end
                        end
                    endcase
                end
            end
            tga_pkg::PH_PACKET:
            begin
                if (pkt_err)
                begin
                    emit             = 1'b1;
                    word_next.status = tga_pkg::ST_OVERFLOW;
                end
                else
                begin
                    pkt_left_next = count;
                    pkt_run_next  = count_run;
                    bip_next      = '0;
                end
            end
            tga_pkg::PH_PIXEL:
            begin
                if (bip_cur < need)
                begin
                    // collect B, G (and R for 32 bpp)
                    case (bip_cur)
                        2'd0:    colour_next[7:0]   = colour_cur[7:0] | b;
                        2'd1:    colour_next[15:8]  = colour_cur[15:8] | b;
                        default: colour_next[23:16] = colour_cur[23:16] | b;
                    endcase
                    bip_next = bip_cur + 2'd1;
                end
                else
                begin
                    emit                   = 1'b1;
                    word_next.blue         = colour_cur[7:0];
                    word_next.green        = colour_cur[15:8];
                    word_next.red          = four_cur ? colour_cur[23:16] : b;
                    word_next.alpha        = four_cur ? b : 8'd0;
                    word_next.has_alpha    = four_cur;
                    word_next.repeat_count = rep;
                    word_next.last_pixel   = (pix_after == 32'd0);
                    word_next.status       = tga_pkg::ST_PIXEL;
                    pix_left_next          = pix_after;
                    if (comp_cur)
                        pkt_left_next = pkt_run_cur ? 8'd0 : (pkt_left_cur - 8'd1);
                    bip_next    = '0;
                    colour_next = '0;
                end
            end
            tga_pkg::PH_DONE,
            tga_pkg::PH_ERROR:
                emit = 1'b0;
            default:
                emit = 1'b0;
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        if (accept)
            valid_next = emit;
        else if (pixel_ready)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    // Advance parser state on each accepted byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= tga_pkg::PH_HEADER;
            hdr_idx_reg  <= '0;
            width_reg    <= '0;
            height_reg   <= '0;
            comp_reg     <= 1'b0;
            four_reg     <= 1'b0;
            pix_left_reg <= '0;
            pkt_left_reg <= '0;
            pkt_run_reg  <= 1'b0;
            colour_reg   <= '0;
            bip_reg      <= '0;
            valid_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (accept)
            begin
                phase_reg    <= phase_next;
                hdr_idx_reg  <= hdr_idx_next;
                width_reg    <= width_next;
                height_reg   <= height_next;
                comp_reg     <= comp_next;
                four_reg     <= four_next;
                pix_left_reg <= pix_left_next;
                pkt_left_reg <= pkt_left_next;
                pkt_run_reg  <= pkt_run_next;
                colour_reg   <= colour_next;
                bip_reg      <= bip_next;
            end
        end
    end

    // Load the output word
    always_ff @(posedge clk)
    begin
        if (accept && emit)
            word_reg <= word_next;
    end

endmodule

>>> tb/sv/tga_decode_checker.sv
`timescale 1ns / 1ps

module tga_decode_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               byte_valid,
    input  logic               byte_ready,
    input  tga_pkg::in_word_t  byte_word,
    input  logic               pixel_valid,
    input  logic               pixel_ready,
    input  tga_pkg::out_word_t pixel_word,
    output int                 fail_count,
    output int                 pending,
    output int                 pixel_words,
    output int                 error_words
);

    // Parser state mirrored from the byte stream
    tga_pkg::phase_t phase;
    logic [4:0]      hdr_idx;
    logic [15:0]     img_w;
    logic [15:0]     img_h;
    logic            rle;
    logic            four;
    logic [31:0]     px_left;
    logic [7:0]      pkt_left;
    logic            pkt_run;
    logic [23:0]     colour;
    logic [1:0]      byte_pos;

    tga_pkg::out_word_t expected_words[$];
    int                 n_fail;
    int                 n_pix;
    int                 n_err;

    task automatic clear_parser();
        phase    = tga_pkg::PH_HEADER;
        hdr_idx  = '0;
        img_w    = '0;
        img_h    = '0;
        rle      = 1'b0;
        four     = 1'b0;
        px_left  = '0;
        pkt_left = '0;
        pkt_run  = 1'b0;
        colour   = '0;
        byte_pos = '0;
    endtask

    // Advance the parser by one file byte; queue the word it should produce
    task automatic decode_byte(input tga_pkg::in_word_t w);
        tga_pkg::out_word_t res;
        logic [7:0]         b;
        logic [4:0]         idx;
        logic [8:0]         cnt;
        logic [7:0]         rep;
        logic [1:0]         need;
        bit                 emit;
        b    = w.data_byte;
        res  = '0;
        emit = 1'b0;
        if (w.file_start)
            clear_parser();
        case (phase)
            tga_pkg::PH_HEADER:
            begin
                idx     = hdr_idx;
                hdr_idx = hdr_idx + 5'd1;
                if (idx < tga_pkg::HDR_PATTERN_END)
                begin
                    if (idx == tga_pkg::HDR_TYPE_IDX)
                    begin
                        if (b == tga_pkg::TYPE_RAW)
                            rle = 1'b0;
                        else if (b == tga_pkg::TYPE_RLE)
                            rle = 1'b1;
                        else
                        begin
                            res.status = tga_pkg::ST_BAD_TYPE;
                            emit = 1'b1;
                        end
                    end
                    else if (b != 8'h00)
                    begin
                        res.status = tga_pkg::ST_BAD_TYPE;
                        emit = 1'b1;
                    end
                end
                else if (idx == tga_pkg::HDR_WIDTH_LO)
                    img_w = {8'h00, b};
                else if (idx == tga_pkg::HDR_WIDTH_HI)
                    img_w[15:8] = b;
                else if (idx == tga_pkg::HDR_HEIGHT_LO)
                    img_h = {8'h00, b};
                else if (idx == tga_pkg::HDR_HEIGHT_HI)
                    img_h[15:8] = b;
                else if (idx == tga_pkg::HDR_DEPTH_IDX)
                begin
                    if (img_w == 16'd0 || img_h == 16'd0 ||
                        (b != tga_pkg::DEPTH_24 && b != tga_pkg::DEPTH_32))
                    begin
                        res.status = tga_pkg::ST_BAD_SIZE;
                        emit = 1'b1;
                    end
                    else
                        four = (b == tga_pkg::DEPTH_32);
                end
                else
                begin
                    // descriptor byte: open the pixel data
                    px_left  = {16'd0, img_w} * {16'd0, img_h};
                    byte_pos = '0;
                    colour   = '0;
                    pkt_left = '0;
                    pkt_run  = 1'b0;
                    phase    = rle ? tga_pkg::PH_PACKET : tga_pkg::PH_PIXEL;
                end
            end
            tga_pkg::PH_PACKET:
            begin
                if (!b[7])
                begin
                    cnt     = {1'b0, b} + 9'd1;
                    pkt_run = 1'b0;
                end
                else
                begin
                    cnt     = {1'b0, b} - {1'b0, tga_pkg::RUN_BASE};
                    pkt_run = 1'b1;
                end
                if ({23'd0, cnt} > px_left)
                begin
                    res.status = tga_pkg::ST_OVERFLOW;
                    emit = 1'b1;
                end
                else
                begin
                    pkt_left = cnt[7:0];
                    byte_pos = '0;
                    phase    = tga_pkg::PH_PIXEL;
                end
            end
            tga_pkg::PH_PIXEL:
            begin
                need = four ? 2'd3 : 2'd2;
                if (byte_pos < need)
                begin
                    colour[8*byte_pos +: 8] = b;
                    byte_pos = byte_pos + 2'd1;
                end
                else
                begin
                    rep = (rle && pkt_run) ? pkt_left : 8'd1;
                    px_left = px_left - {24'd0, rep};
                    if (rle)
                        pkt_left = pkt_run ? 8'd0 : pkt_left - 8'd1;
                    res.blue         = colour[7:0];
                    res.green        = colour[15:8];
                    res.red          = four ? colour[23:16] : b;
                    res.alpha        = four ? b : 8'h00;
                    res.has_alpha    = four;
                    res.repeat_count = rep;
                    res.last_pixel   = (px_left == 32'd0);
                    res.status       = tga_pkg::ST_PIXEL;
                    emit     = 1'b1;
                    byte_pos = '0;
                    colour   = '0;
                    if (px_left == 32'd0)
                        phase = tga_pkg::PH_DONE;
                    else if (rle && pkt_left == 8'd0)
                        phase = tga_pkg::PH_PACKET;
                end
            end
            default:
                ;
        endcase
        if (emit && res.status != tga_pkg::ST_PIXEL)
            phase = tga_pkg::PH_ERROR;
        if (emit)
            expected_words.push_back(res);
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_fail++;
        end
    endtask

    // Compare each pixel word taken, then track the byte taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin : watch
        tga_pkg::out_word_t want;
        if (!rst_n)
        begin
            clear_parser();
            expected_words.delete();
            n_fail = 0;
            n_pix  = 0;
            n_err  = 0;
            fail_count  <= 0;
            pending     <= 0;
            pixel_words <= 0;
            error_words <= 0;
        end
        else
        begin
            if (pixel_valid && pixel_ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $error("pixel word with nothing expected: status %0d", pixel_word.status);
                    n_fail++;
                end
                else
                begin
                    want = expected_words.pop_front();
                    check_field("red", want.red, pixel_word.red);
                    check_field("green", want.green, pixel_word.green);
                    check_field("blue", want.blue, pixel_word.blue);
                    check_field("alpha", want.alpha, pixel_word.alpha);
                    check_field("has_alpha", 8'(want.has_alpha), 8'(pixel_word.has_alpha));
                    check_field("repeat_count", want.repeat_count, pixel_word.repeat_count);
                    check_field("last_pixel", 8'(want.last_pixel), 8'(pixel_word.last_pixel));
                    check_field("status", 8'(want.status), 8'(pixel_word.status));
                    if (want.status == tga_pkg::ST_PIXEL)
                        n_pix++;
                    else
                        n_err++;
                end
            end
            if (byte_valid && byte_ready)
                decode_byte(byte_word);
            fail_count  <= n_fail;
            pending     <= expected_words.size();
            pixel_words <= n_pix;
            error_words <= n_err;
        end
    end

endmodule

>>> tb/sv/tb_tga_rle_image_decoder_unit.sv
`timescale 1ns / 1ps

module tb_tga_rle_image_decoder_unit;

    localparam int ITEMS       = 1950;
    localparam int QUIET_TAIL  = 300;
    localparam int HOLD_CYCLES = 300;

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               byte_valid  = 1'b0;
    logic               byte_ready;
    tga_pkg::in_word_t  byte_word   = '0;
    logic               pixel_valid;
    logic               pixel_ready = 1'b0;
    tga_pkg::out_word_t pixel_word;

    int fail_count;
    int pending;
    int pixel_words;
    int error_words;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    bit src_gaps = 1'b1;
    int sent       = 0;
    int files_sent = 0;

    tga_pkg::in_word_t file_q[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    tga_rle_image_decoder_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_word   (byte_word),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_word  (pixel_word)
    );

    tga_decode_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_valid  (byte_valid),
        .byte_ready  (byte_ready),
        .byte_word   (byte_word),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel_word  (pixel_word),
        .fail_count  (fail_count),
        .pending     (pending),
        .pixel_words (pixel_words),
        .error_words (error_words)
    );

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic void add_byte(input logic [7:0] b, input bit start = 1'b0);
        tga_pkg::in_word_t w;
        w.data_byte  = b;
        w.file_start = start;
        file_q.push_back(w);
    endfunction

    function automatic void add_pixel(input int n);
        repeat (n) add_byte(pick_byte());
    endfunction

    // Build the 18-byte file header
    function automatic void add_header(input logic [7:0] img_type, input logic [15:0] w,
                                       input logic [15:0] h, input logic [7:0] depth);
        add_byte(8'h00, 1'b1);
        add_byte(8'h00);
        add_byte(img_type);
        repeat (9) add_byte(8'h00);
        add_byte(w[7:0]);
        add_byte(w[15:8]);
        add_byte(h[7:0]);
        add_byte(h[15:8]);
        add_byte(depth);
        add_byte(8'($urandom));
    endfunction

    // Append pixel data for a frame, stopping early once cap bytes are queued
    function automatic void add_body(input bit rle, input bit four, input longint total,
                                     input int cap);
        longint left;
        int     cnt;
        int     bpp;
        left = total;
        bpp  = four ? 4 : 3;
        while (left > 0 && file_q.size() < cap)
        begin
            if (!rle)
            begin
                add_pixel(bpp);
                left--;
            end
            else
            begin
                cnt = (left < 128) ? $urandom_range(1, int'(left)) : $urandom_range(1, 128);
                if ($urandom_range(0, 1))
                begin
                    add_byte(8'(tga_pkg::RUN_BASE + cnt));
                    add_pixel(bpp);
                end
                else
                begin
                    add_byte(8'(cnt - 1));
                    repeat (cnt) add_pixel(bpp);
                end
                left -= cnt;
            end
        end
    endfunction

    function automatic void make_image(input bit rle, input bit four, input int w, input int h,
                                       input int cap);
        add_header(rle ? tga_pkg::TYPE_RLE : tga_pkg::TYPE_RAW, 16'(w), 16'(h),
                   four ? tga_pkg::DEPTH_32 : tga_pkg::DEPTH_24);
        add_body(rle, four, longint'(w) * longint'(h), cap);
    endfunction

    // Offer one word; hold valid and payload until the block takes it
    task automatic push_word(input tga_pkg::in_word_t w);
        int gap;
        if (!quiet && src_gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 19);
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_word  <= w;
        do
            @(posedge clk);
        while (!byte_ready);
        sent++;
    endtask

    task automatic send_file();
        foreach (file_q[i])
            push_word(file_q[i]);
        file_q.delete();
        files_sent++;
    endtask

    // Pixel sink: random stall bursts, one long hold-off, none at the tail
    initial
    begin : pixel_sink
        int burst;
        int mode_left;
        bit stalls;
        bit held;
        stalls    = 1'b1;
        held      = 1'b0;
        mode_left = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                stalls    = ($urandom_range(0, 3) != 0);
                mode_left = $urandom_range(50, 400);
            end
            mode_left--;
            if (hold_req && !held)
            begin
                held = 1'b1;
                pixel_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                pixel_ready <= 1'b1;
            end
            else if (!quiet && stalls && $urandom_range(0, 4) == 0)
            begin
                burst = $urandom_range(1, 19);
                pixel_ready <= 1'b0;
                repeat (burst) @(posedge clk);
                pixel_ready <= 1'b1;
            end
            else
                pixel_ready <= 1'b1;
        end
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    initial
    begin : stimulus
        int         kind;
        int         w;
        int         h;
        int         cut;
        int         cnt;
        int         total;
        bit         rle;
        bit         four;
        logic [7:0] depth;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first byte off the header pattern
        add_byte(8'hFF, 1'b1);
        send_file();
        // unknown image type
        add_header(8'h07, 16'd1, 16'd1, tga_pkg::DEPTH_24);
        file_q = file_q[0:2];
        send_file();
        // zero width, then a bad depth
        add_header(tga_pkg::TYPE_RAW, 16'd0, 16'd1, tga_pkg::DEPTH_24);
        send_file();
        add_header(tga_pkg::TYPE_RLE, 16'd1, 16'd1, 8'd16);
        send_file();
        // one 32 bpp raw pixel, trailing byte dropped
        add_header(tga_pkg::TYPE_RAW, 16'd1, 16'd1, tga_pkg::DEPTH_32);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'hFF);
        add_byte(8'h00);
        add_byte(8'hA5);
        send_file();
        // run packet longer than the frame
        add_header(tga_pkg::TYPE_RLE, 16'd1, 16'd1, tga_pkg::DEPTH_32);
        add_byte(8'hFF);
        send_file();
        // full 128 run, one-pixel raw packet, one-pixel run
        add_header(tga_pkg::TYPE_RLE, 16'd130, 16'd1, tga_pkg::DEPTH_24);
        add_byte(8'hFF);
        add_pixel(3);
        add_byte(8'h00);
        add_pixel(3);
        add_byte(8'h80);
        add_pixel(3);
        send_file();
        // restart in mid header
        add_header(tga_pkg::TYPE_RAW, 16'd2, 16'd2, tga_pkg::DEPTH_24);
        file_q = file_q[0:9];
        send_file();

        while (sent < ITEMS)
        begin
            if (sent >= ITEMS - QUIET_TAIL)
                quiet <= 1'b1;
            src_gaps = ($urandom_range(0, 3) != 0);
            rle  = $urandom_range(0, 1);
            four = $urandom_range(0, 1);
            if (!hold_req && sent >= ITEMS / 3)
            begin
                // raw frame that keeps producing words during the long hold-off
                hold_req <= 1'b1;
                make_image(1'b0, 1'b0, 8, 8, 1 << 20);
            end
            else
            begin
                kind = $urandom_range(0, 19);
                case (kind)
                    13:
                    begin
                        // huge frame, cut short by the next file
                        w = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
                        h = $urandom_range(0, 1) ? 65535 : $urandom_range(1, 65535);
                        make_image(rle, four, w, h, 60);
                    end
                    14, 15:
                    begin
                        // break one byte of the fixed pattern
                        make_image(rle, four, $urandom_range(1, 3), $urandom_range(1, 2), 1 << 20);
                        cut = $urandom_range(0, 11);
                        if (cut == tga_pkg::HDR_TYPE_IDX)
                        begin
                            do
                                file_q[cut].data_byte = pick_byte();
                            while (file_q[cut].data_byte == tga_pkg::TYPE_RAW ||
                                   file_q[cut].data_byte == tga_pkg::TYPE_RLE);
                        end
                        else
                            file_q[cut].data_byte = 8'($urandom_range(1, 255));
                    end
                    16:
                    begin
                        // zero dimension or unsupported depth
                        w = $urandom_range(0, 3);
                        h = $urandom_range(0, 3);
                        if (w != 0 && h != 0)
                        begin
                            do
                                depth = pick_byte();
                            while (depth == tga_pkg::DEPTH_24 || depth == tga_pkg::DEPTH_32);
                        end
                        else
                            depth = four ? tga_pkg::DEPTH_32 : tga_pkg::DEPTH_24;
                        add_header(rle ? tga_pkg::TYPE_RLE : tga_pkg::TYPE_RAW, 16'(w), 16'(h),
                                   depth);
                        add_pixel($urandom_range(0, 4));
                    end
                    17:
                    begin
                        // packet that runs past the frame
                        w = $urandom_range(1, 4);
                        h = $urandom_range(1, 4);
                        total = w * h;
                        add_header(tga_pkg::TYPE_RLE, 16'(w), 16'(h),
                                   four ? tga_pkg::DEPTH_32 : tga_pkg::DEPTH_24);
                        if (total > 1 && $urandom_range(0, 1))
                        begin
                            add_byte(8'h80);
                            add_pixel(four ? 4 : 3);
                            total--;
                        end
                        cnt = $urandom_range(total + 1, 128);
                        add_byte($urandom_range(0, 1) ? 8'(tga_pkg::RUN_BASE + cnt)
                                                      : 8'(cnt - 1));
                        add_pixel($urandom_range(0, 4));
                    end
                    18:
                    begin
                        // loose bytes, some restarting the parser
                        repeat ($urandom_range(1, 8))
                            add_byte(pick_byte(), $urandom_range(0, 3) == 0);
                    end
                    19:
                    begin
                        // header cut off by the next file
                        make_image(rle, four, 1, 1, 1 << 20);
                        file_q = file_q[0:$urandom_range(0, 16)];
                    end
                    default:
                    begin
                        // well-formed frame, sometimes truncated or with trailing bytes
                        if ($urandom_range(0, 7) == 0)
                        begin
                            rle = 1'b1;
                            w = $urandom_range(8, 24);
                            h = $urandom_range(6, 10);
                        end
                        else
                        begin
                            w = $urandom_range(1, 6);
                            h = $urandom_range(1, 4);
                        end
                        // keep the last frame from running far past the byte budget
                        make_image(rle, four, w, h, ITEMS - sent + 64);
                        if ($urandom_range(0, 5) == 0)
                            file_q = file_q[0:$urandom_range(18, file_q.size() - 1)];
                        if ($urandom_range(0, 3) == 0)
                            add_pixel($urandom_range(1, 4));
                    end
                endcase
            end
            send_file();
        end
        byte_valid <= 1'b0;

        // drain outstanding words, then let the bench idle before reporting
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("sent %0d bytes in %0d files; checked %0d pixel words and %0d error words",
                 sent, files_sent, pixel_words, error_words);
        $display("raw and run-coded frames at 24/32 bpp, header faults, overflow, restarts, stall");
        if (fail_count == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
